[src/iirlp_pkg.sv]
package iirlp_pkg;

  localparam int FILTER_ORDER = 10;
  localparam int NUM_SENSORS  = 2;
  localparam int COEF_WIDTH   = 24;
  localparam int CF           = COEF_WIDTH - 5;
  localparam int SAMPLE_W     = 16;
  localparam int TAPS         = 2 * FILTER_ORDER + 1;
  localparam int TAP_W        = $clog2(TAPS);
  localparam int PROD_W       = SAMPLE_W + COEF_WIDTH;
  localparam int ACC_W        = PROD_W + TAP_W;
  localparam int RES_W        = ACC_W - CF;
  localparam int NTAB         = 11;

  // butterworth coefficients scaled by 10000
  localparam int NUM_TAB [NTAB] = '{1, 9, 41, 109, 191, 229, 191, 109, 41, 9, 1};
  localparam int DEN_TAB [NTAB] = '{10000, -35249, 66114, -80046, 68123, -41900,
                                    18711, -5948, 1282, -169, 10};

  typedef logic signed [SAMPLE_W-1:0]   sample_t;
  typedef logic signed [COEF_WIDTH-1:0] coef_t;
  typedef coef_t                        coef_tab_t [TAPS];

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_ROUND,
    ST_PUSH
  } state_e;

  typedef struct packed {
    logic             start;
    logic             mul_en;
    logic             acc_en;
    logic             commit;
    logic             sel;
    logic [TAP_W-1:0] tap;
  } lane_ctl_t;

  localparam sample_t SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam sample_t SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // round to nearest, ties away from zero
  function automatic coef_t quantize(int k);
    longint mag;
    longint q;
    mag = (k < 0) ? -longint'(k) : longint'(k);
    q   = (mag * (longint'(1) << CF) + 64'sd5000) / 64'sd10000;
    return (k < 0) ? coef_t'(-q) : coef_t'(q);
  endfunction

  // feedforward taps first, then the negated feedback taps
  function automatic coef_tab_t build_coefs();
    coef_tab_t t;
    int        k;
    int        j;
    for (int i = 0; i < TAPS; i++) begin
      if (i <= FILTER_ORDER) begin
        k = (i < NTAB) ? NUM_TAB[i] : 0;
      end else begin
        j = i - FILTER_ORDER;
        k = (j < NTAB) ? -DEN_TAB[j] : 0;
      end
      t[i] = quantize(k);
    end
    return t;
  endfunction

  localparam coef_tab_t COEFS = build_coefs();

endpackage

[src/iirlp_lane.sv]
module iirlp_lane (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  iirlp_pkg::lane_ctl_t ctl_i,
  input  iirlp_pkg::sample_t   sample_i,
  output iirlp_pkg::sample_t   filt_o
);
  import iirlp_pkg::*;

  // per sensor: inputs at 0..order, outputs after; rotated so tap t sits at 0
  sample_t                   hist_q [NUM_SENSORS][TAPS];
  sample_t                   head;
  logic signed [PROD_W-1:0]  prod_d;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [ACC_W-1:0]   acc_rnd;
  logic signed [RES_W-1:0]   res;
  sample_t                   y_d;
  sample_t                   y_q;

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (CF - 1);

  assign head   = hist_q[ctl_i.sel][0];
  assign prod_d = head * COEFS[ctl_i.tap];

  // round half up, then saturate
  assign acc_rnd = acc_q + RND_HALF;
  assign res     = acc_rnd[ACC_W-1:CF];

  always_comb begin
    if ((&res[RES_W-1:SAMPLE_W-1]) || !(|res[RES_W-1:SAMPLE_W-1])) begin
      y_d = res[SAMPLE_W-1:0];
    end else if (res[RES_W-1]) begin
      y_d = SAT_MIN;
    end else begin
      y_d = SAT_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_SENSORS; s++) begin
        for (int i = 0; i < TAPS; i++) begin
          hist_q[s][i] <= '0;
        end
      end
    end else begin
      for (int s = 0; s < NUM_SENSORS; s++) begin
        if (ctl_i.sel == 1'(s)) begin
          if (ctl_i.start) begin
            hist_q[s][0] <= sample_i;
            for (int i = 1; i <= FILTER_ORDER; i++) begin
              hist_q[s][i] <= hist_q[s][i-1];
            end
          end else if (ctl_i.mul_en) begin
            for (int i = 0; i < TAPS - 1; i++) begin
              hist_q[s][i] <= hist_q[s][i+1];
            end
            hist_q[s][TAPS-1] <= hist_q[s][0];
          end else if (ctl_i.commit) begin
            hist_q[s][FILTER_ORDER+1] <= y_d;
            for (int i = FILTER_ORDER + 2; i < TAPS; i++) begin
              hist_q[s][i] <= hist_q[s][i-1];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (ctl_i.start) begin
      acc_q <= '0;
    end else if (ctl_i.acc_en) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    if (ctl_i.commit) begin
      y_q <= y_d;
    end
  end

  assign filt_o = y_q;

endmodule

[src/iirlp_ctrl.sv]
module iirlp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 sensor_sel_i,
  input  logic                 out_busy_i,
  output logic                 in_stall_o,
  output logic                 load_out_o,
  output logic                 sel_ok_o,
  output iirlp_pkg::lane_ctl_t lane_ctl_o
);
  import iirlp_pkg::*;

  state_e           state_q, state_d;
  logic [TAP_W-1:0] tap_q, tap_d;
  logic             sel_q;
  logic             ok_q;
  logic             in_ok;
  logic             accept;

  assign in_ok  = int'(sensor_sel_i) < NUM_SENSORS;
  assign accept = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    tap_d   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = in_ok ? ST_MAC : ST_PUSH;
        end
      end
      ST_MAC: begin
        tap_d = tap_q + 1'b1;
        if (tap_q == TAP_W'(TAPS - 1)) begin
          state_d = ST_DRAIN;
          tap_d   = '0;
        end
      end
      ST_DRAIN: state_d = ST_ROUND;
      ST_ROUND: state_d = ST_PUSH;
      ST_PUSH: begin
        if (!out_busy_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o        = 1'b1;
    load_out_o        = 1'b0;
    lane_ctl_o.start  = 1'b0;
    lane_ctl_o.mul_en = 1'b0;
    lane_ctl_o.acc_en = 1'b0;
    lane_ctl_o.commit = 1'b0;
    lane_ctl_o.sel    = sel_q;
    lane_ctl_o.tap    = tap_q;
    case (state_q)
      ST_IDLE: begin
        in_stall_o       = 1'b0;
        lane_ctl_o.sel   = sensor_sel_i;
        lane_ctl_o.start = in_valid_i && in_ok;
      end
      ST_MAC: begin
        lane_ctl_o.mul_en = 1'b1;
        lane_ctl_o.acc_en = (tap_q != '0);
      end
      ST_DRAIN: lane_ctl_o.acc_en = 1'b1;
      ST_ROUND: lane_ctl_o.commit = 1'b1;
      ST_PUSH:  load_out_o        = !out_busy_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tap_q   <= '0;
      sel_q   <= 1'b0;
      ok_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      tap_q   <= tap_d;
      if (accept) begin
        sel_q <= sensor_sel_i;
        ok_q  <= in_ok;
      end
    end
  end

  assign sel_ok_o = ok_q;

endmodule

[src/imu_axis_iir_lowpass.sv]
// channel  | dir | handshake               | payload
// ---------+-----+-------------------------+------------------------------------
// request  | in  | in_valid_i / in_stall_o | sensor_sel_i, accel_x_i, accel_y_i
// result   | out | out_valid_o/out_stall_i | sensor_id_o, filt_x_o, filt_y_o
//
// a request runs accept, 21 multiply-accumulate steps on the single multiplier of
// each axis lane, drain, round and push to the output register, one request at a time
// a request with a sensor index beyond the sensor count skips the taps and yields zeros
// rst_ni clears all filter history and control state at once; no clearing pass
// a stalled result sits in the output register while the next request is taken;
// a finished request waits in the push step only while that register is still held
module imu_axis_iir_lowpass (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               sensor_sel_i,
  input  iirlp_pkg::sample_t accel_x_i,
  input  iirlp_pkg::sample_t accel_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               sensor_id_o,
  output iirlp_pkg::sample_t filt_x_o,
  output iirlp_pkg::sample_t filt_y_o
);
  import iirlp_pkg::*;

  lane_ctl_t lane_ctl;
  logic      load_out;
  logic      sel_ok;
  logic      out_busy;
  sample_t   lane_x;
  sample_t   lane_y;

  // output register of the merge stage
  logic      out_valid_q;
  logic      sensor_id_q;
  sample_t   filt_x_q;
  sample_t   filt_y_q;

  assign out_busy = out_valid_q && out_stall_i;

  // sequencer: walks the taps in lockstep for both lanes
  iirlp_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .sensor_sel_i (sensor_sel_i),
    .out_busy_i   (out_busy),
    .in_stall_o   (in_stall_o),
    .load_out_o   (load_out),
    .sel_ok_o     (sel_ok),
    .lane_ctl_o   (lane_ctl)
  );

  // x axis lane
  iirlp_lane u_lane_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (lane_ctl),
    .sample_i (accel_x_i),
    .filt_o   (lane_x)
  );

  // y axis lane
  iirlp_lane u_lane_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (lane_ctl),
    .sample_i (accel_y_i),
    .filt_o   (lane_y)
  );

  // merge: pair both axes with the echoed index, zeros for an unknown sensor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      sensor_id_q <= lane_ctl.sel;
      filt_x_q    <= sel_ok ? lane_x : '0;
      filt_y_q    <= sel_ok ? lane_y : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sensor_id_o = sensor_id_q;
  assign filt_x_o    = filt_x_q;
  assign filt_y_o    = filt_y_q;

endmodule

[src/iirlp_checker.sv]
module iirlp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               sensor_id_o,
  input iirlp_pkg::sample_t filt_x_o,
  input iirlp_pkg::sample_t filt_y_o
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sensor_id_o)
      && $stable(filt_x_o) && $stable(filt_y_o))
    else $error("stalled result changed");

  // a taken request keeps the block busy, so no second request follows right behind it
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o ##1 in_stall_o)
    else $error("request taken too soon after previous one");

  // leaving busy always hands over a result
  a_done_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> out_valid_o)
    else $error("block went idle without a result");

  // a new result only comes out of a busy block
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without work");

endmodule

bind imu_axis_iir_lowpass iirlp_checker u_iirlp_checker (.*);

[dv/tb_imu_axis_iir_lowpass.sv]
module tb_imu_axis_iir_lowpass;
  import iirlp_pkg::*;

  localparam int NCHAN     = 2 * NUM_SENSORS;
  localparam int STALL_CAP = 4000;  // cycles with no handshake before giving up
  localparam int TAIL_WAIT = 60;    // extra wait after the last drain before the final verdict

  typedef struct {
    logic    sel;
    sample_t ax;
    sample_t ay;
  } imu_req_t;

  typedef struct {
    logic    id;
    sample_t fx;
    sample_t fy;
  } filt_res_t;

  logic    clk_i        = 1'b0;
  logic    rst_ni       = 1'b0;
  logic    in_valid_i   = 1'b0;
  logic    sensor_sel_i = 1'b0;
  sample_t accel_x_i    = '0;
  sample_t accel_y_i    = '0;
  logic    out_stall_i  = 1'b0;
  logic    in_stall_o;
  logic    out_valid_o;
  logic    sensor_id_o;
  sample_t filt_x_o;
  sample_t filt_y_o;

  imu_req_t  req_queue[$];
  filt_res_t expected_filt[$];
  int        err_count      = 0;
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;
  logic      req_taken      = 1'b0;

  // filter state of the predictor
  longint  num_coef [FILTER_ORDER+1];
  longint  den_coef [FILTER_ORDER+1];
  sample_t x_hist   [NCHAN][FILTER_ORDER+1];
  sample_t y_hist   [NCHAN][FILTER_ORDER];

  // butterworth coefficients times 10000
  int num_x10k [11] = '{1, 9, 41, 109, 191, 229, 191, 109, 41, 9, 1};
  int den_x10k [11] = '{10000, -35249, 66114, -80046, 68123, -41900,
                        18711, -5948, 1282, -169, 10};

  imu_axis_iir_lowpass dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sensor_sel_i (sensor_sel_i),
    .accel_x_i    (accel_x_i),
    .accel_y_i    (accel_y_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sensor_id_o  (sensor_id_o),
    .filt_x_o     (filt_x_o),
    .filt_y_o     (filt_y_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // decimal coefficient to fixed point, nearest with ties away from zero
  function automatic longint to_fixed(int k);
    longint mag;
    longint q;
    mag = (k < 0) ? -longint'(k) : longint'(k);
    q   = (mag * (longint'(1) << CF) + 5000) / 10000;
    return (k < 0) ? -q : q;
  endfunction

  // one direct-form-i step of one channel: shift, mac, round, saturate
  function automatic sample_t iir_channel_step(int ch, sample_t x);
    longint acc;
    longint r;
    sample_t y;
    for (int i = FILTER_ORDER; i > 0; i--) x_hist[ch][i] = x_hist[ch][i-1];
    x_hist[ch][0] = x;
    acc = 0;
    for (int i = 0; i <= FILTER_ORDER; i++) acc += num_coef[i] * longint'(x_hist[ch][i]);
    for (int i = 1; i <= FILTER_ORDER; i++) acc -= den_coef[i] * longint'(y_hist[ch][i-1]);
    // add half an lsb, then arithmetic shift floors: ties go up
    r = (acc + (longint'(1) << (CF - 1))) >>> CF;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    y = sample_t'(r);
    for (int i = FILTER_ORDER - 1; i > 0; i--) y_hist[ch][i] = y_hist[ch][i-1];
    y_hist[ch][0] = y;
    return y;
  endfunction

  function automatic filt_res_t predict_filt(imu_req_t req);
    filt_res_t res;
    res.id = req.sel;
    res.fx = '0;
    res.fy = '0;
    // an index past the sensor count leaves history alone and yields zeros
    if (int'(req.sel) < NUM_SENSORS) begin
      res.fx = iir_channel_step(2 * int'(req.sel), req.ax);
      res.fy = iir_channel_step(2 * int'(req.sel) + 1, req.ay);
    end
    return res;
  endfunction

  function automatic sample_t clamp16(int v);
    if (v > 32767) return sample_t'(32767);
    if (v < -32768) return sample_t'(-32768);
    return sample_t'(v);
  endfunction

  task automatic add_req(logic sel, sample_t ax, sample_t ay);
    imu_req_t req;
    req.sel = sel;
    req.ax  = ax;
    req.ay  = ay;
    req_queue.push_back(req);
  endtask

  // bursts of random requests: settled levels, rail-to-rail steps, small
  // signals and plain noise, with the sensors interleaved
  task automatic add_random_reqs(int n);
    int   left;
    int   len;
    int   mode;
    int   lvl_x;
    int   lvl_y;
    logic s;
    logic sel;
    left = n;
    while (left > 0) begin
      mode = $urandom_range(9);
      len  = $urandom_range(40, 8);
      if (len > left) len = left;
      s     = $urandom_range(1);
      lvl_x = int'($urandom_range(65535)) - 32768;
      lvl_y = int'($urandom_range(65535)) - 32768;
      for (int i = 0; i < len; i++) begin
        sel = ($urandom_range(3) == 0) ? ~s : s;
        if (mode < 4) begin
          // held level with noise so the output settles on it
          add_req(sel, clamp16(lvl_x + int'($urandom_range(512)) - 256),
                  clamp16(lvl_y + int'($urandom_range(512)) - 256));
        end else if (mode < 6) begin
          // rails held for a while, flipping now and then: overshoot and saturation
          if ($urandom_range(7) == 0) lvl_x = (lvl_x > 0) ? -32768 : 32767;
          if ($urandom_range(7) == 0) lvl_y = (lvl_y > 0) ? -32768 : 32767;
          add_req(sel, clamp16((lvl_x > 0) ? 32767 : -32768),
                  clamp16((lvl_y > 0) ? 32767 : -32768));
        end else if (mode < 8) begin
          add_req(sel, sample_t'($urandom_range(65535)), sample_t'($urandom_range(65535)));
        end else begin
          add_req(sel, clamp16(int'($urandom_range(127)) - 64),
                  clamp16(int'($urandom_range(127)) - 64));
        end
      end
      left -= len;
    end
  endtask

  task automatic drain_phase();
    while (req_queue.size() != 0 || expected_filt.size() != 0 || in_valid_i)
      @(negedge clk_i);
  endtask

  // request driver: a new request only once the current one is taken
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || req_taken) begin
      if (req_queue.size() != 0 && int'($urandom_range(99)) >= send_idle_pct) begin
        in_valid_i   <= 1'b1;
        sensor_sel_i <= req_queue[0].sel;
        accel_x_i    <= req_queue[0].ax;
        accel_y_i    <= req_queue[0].ay;
        void'(req_queue.pop_front());
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    out_stall_i <= rst_ni && (int'($urandom_range(99)) < recv_stall_pct);
  end

  // predict on every accepted request
  always @(posedge clk_i) begin
    imu_req_t req;
    req_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      req.sel = sensor_sel_i;
      req.ax  = accel_x_i;
      req.ay  = accel_y_i;
      expected_filt.push_back(predict_filt(req));
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    filt_res_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_filt.size() == 0) begin
        $error("unexpected result: sensor_id %0d filt_x %0d filt_y %0d",
               sensor_id_o, filt_x_o, filt_y_o);
        err_count++;
      end else begin
        exp_res = expected_filt.pop_front();
        if (sensor_id_o !== exp_res.id) begin
          $error("sensor_id: expected %0d, got %0d", exp_res.id, sensor_id_o);
          err_count++;
        end
        if (filt_x_o !== exp_res.fx) begin
          $error("filt_x: expected %0d, got %0d", exp_res.fx, filt_x_o);
          err_count++;
        end
        if (filt_y_o !== exp_res.fy) begin
          $error("filt_y: expected %0d, got %0d", exp_res.fy, filt_y_o);
          err_count++;
        end
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk_i) begin
    int quiet_cycles;
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_CAP) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i <= FILTER_ORDER; i++) begin
      num_coef[i] = (i < 11) ? to_fixed(num_x10k[i]) : 0;
      den_coef[i] = (i < 11) ? to_fixed(den_x10k[i]) : 0;
    end
    for (int c = 0; c < NCHAN; c++) begin
      for (int i = 0; i <= FILTER_ORDER; i++) x_hist[c][i] = '0;
      for (int i = 0; i < FILTER_ORDER; i++) y_hist[c][i] = '0;
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: rail steps on both sensors, full swings, tiny values, bit patterns
    for (int i = 0; i < 6; i++) add_req(1'b0, sample_t'(32767), sample_t'(-32768));
    add_req(1'b1, '0, '0);
    for (int i = 0; i < 4; i++) add_req(1'b1, sample_t'(-32768), sample_t'(32767));
    for (int i = 0; i < 4; i++) add_req(1'b0, sample_t'(-32768), sample_t'(32767));
    add_req(1'b1, sample_t'(1), sample_t'(-1));
    add_req(1'b1, sample_t'(-1), sample_t'(1));
    add_req(1'b0, sample_t'(16'h5555), sample_t'(16'haaaa));
    add_req(1'b0, sample_t'(16'haaaa), sample_t'(16'h5555));

    // no idling on either side
    add_random_reqs(300);
    drain_phase();

    // sender mostly idle
    send_idle_pct  = 83;
    recv_stall_pct = 0;
    add_random_reqs(340);
    drain_phase();

    // receiver mostly stalling
    send_idle_pct  = 0;
    recv_stall_pct = 83;
    add_random_reqs(340);
    drain_phase();

    // both sides idle now and then
    send_idle_pct  = 31;
    recv_stall_pct = 31;
    add_random_reqs(340);
    drain_phase();

    // any stray result in the tail is flagged by the monitor
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (err_count == 0 && expected_filt.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
src/iirlp_pkg.sv
src/iirlp_lane.sv
src/iirlp_ctrl.sv
src/imu_axis_iir_lowpass.sv
src/iirlp_checker.sv
dv/tb_imu_axis_iir_lowpass.sv
